@@ rtl/sprite_priority_compositor_top_assert.svh @@
// Assertion macros used by the compositor top level.
`ifndef SPRITE_PRIORITY_COMPOSITOR_TOP_ASSERT_SVH
`define SPRITE_PRIORITY_COMPOSITOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/spc_pkg.sv @@
// Shared types, codes and constants of the sprite priority compositor.
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

   // Default sizes of the object table and the art memory.
   localparam int SPC_MAX_OBJECTS = 16;
   localparam int SPC_ART_WORDS   = 4096;

   // Width of the art address sum: base + dy * w + dx.
   localparam int SUM_W = 17;

   // Operation codes.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_ART   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Character and color constants.
   localparam logic [7:0] SPACE_CHAR       = 8'd32;
   localparam logic [7:0] NO_COVER_COLOR   = 8'd1;
   localparam logic [7:0] EMPTY_CHAR_RESET = 8'd32;

   // One object record as stored in the table memory.
   typedef struct packed {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [7:0]         w;
      logic [7:0]         h;
      logic [6:0]         color;
      logic [11:0]        base;
   } spc_obj_type;

   // Registered hit test of one table entry.
   typedef struct packed {
      logic        vld;
      logic        hit;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [7:0]  w;
      logic [6:0]  color;
      logic [11:0] base;
   } spc_hit_type;

endpackage

`default_nettype wire

@@ rtl/spc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/spc_hit.sv @@
// Registered hit test of one object record against the query point.
`timescale 1ns / 1ps
`default_nettype none

module spc_hit (
   input  wire logic                signed [11:0] qx,
   input  wire logic                signed [11:0] qy,
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_vld,
   input  wire spc_pkg::spc_obj_type obj,
   output spc_pkg::spc_hit_type     hit
);

   logic [12:0]          dxs;
   logic [12:0]          dys;
   logic                 in_x;
   logic                 in_y;
   spc_pkg::spc_hit_type hit_in;
   spc_pkg::spc_hit_type hit_ff;

   // Offsets of the point inside the box; the box holds 0 <= d < size.
   always_comb begin
      dxs  = {qx[11], qx} - {obj.x[11], obj.x};
      dys  = {qy[11], qy} - {obj.y[11], obj.y};
      in_x = !dxs[12] && (dxs[11:0] < {4'd0, obj.w});
      in_y = !dys[12] && (dys[11:0] < {4'd0, obj.h});
      hit_in.vld   = rd_vld;
      hit_in.hit   = in_x && in_y;
      hit_in.dx    = dxs[7:0];
      hit_in.dy    = dys[7:0];
      hit_in.w     = obj.w;
      hit_in.color = obj.color;
      hit_in.base  = obj.base;
   end

   // Valid flag is cleared by reset; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff.vld <= 1'b0;
      end else begin
         hit_ff.vld <= hit_in.vld;
      end
      hit_ff.hit   <= hit_in.hit;
      hit_ff.dx    <= hit_in.dx;
      hit_ff.dy    <= hit_in.dy;
      hit_ff.w     <= hit_in.w;
      hit_ff.color <= hit_in.color;
      hit_ff.base  <= hit_in.base;
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

@@ rtl/sprite_priority_compositor_top.sv @@
// Top level of the sprite priority compositor: sequencer, table and art memories.
`timescale 1ns / 1ps
`default_nettype none

// Usage: an item is taken at a rising edge with start high and busy low. req_op selects
// add object, write art byte, query point or clear table. Every item gives one result
// beat: rsp_valid is high for one cycle with the result fields, and the receiver cannot
// stall it. Add, art write and clear finish in the accept cycle; their beat comes in the
// next cycle and busy stays low, so they can be issued back to back.
// A query walks the object table in insertion order, one entry read per cycle from the
// table memory, with the hit test registered behind the read. A hit gives the beat after
// the hit test, the address multiply and the art memory read. A miss gives the beat once
// the last stored object has been tested, or from the first scan state when the table is
// empty. busy is high from the cycle after a query accept until its beat is loaded, so the
// scan (up to MAX_OBJECTS entries) and a hit's art read set the query rate.
// The csr_ write channel loads the empty character; write it only while the block is idle.
// Reset empties the table and sets the empty character to a space. Table and art
// contents are not cleared. ART_WORDS must be a power of two; art addresses wrap at it.

module sprite_priority_compositor_top #(
   parameter int MAX_OBJECTS = spc_pkg::SPC_MAX_OBJECTS,
   parameter int ART_WORDS   = spc_pkg::SPC_ART_WORDS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Command channel.
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [11:0] req_pos_x,
   input  wire logic signed [11:0] req_pos_y,
   input  wire logic [7:0]         req_size_w,
   input  wire logic [7:0]         req_size_h,
   input  wire logic [6:0]         req_color_in,
   input  wire logic [11:0]        req_art_addr,
   input  wire logic [7:0]         req_art_char,
   // Result channel.
   output logic                    rsp_valid,
   output logic [7:0]              rsp_pixel_char,
   output logic [7:0]              rsp_pixel_color,
   output logic                    rsp_covered,
   output logic                    rsp_list_full,
   // Configuration channel.
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_empty_char
);

   `include "sprite_priority_compositor_top_assert.svh"

   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam int TW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int AW = $clog2(ART_WORDS);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_OBJECTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_ART  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic signed [11:0]   qx_ff, qx_in;
   logic signed [11:0]   qy_ff, qy_in;
   logic [15:0]          prod_ff, prod_in;
   logic [12:0]          part_ff, part_in;
   logic [6:0]           color_ff, color_in;
   logic [7:0]           empty_char_ff, empty_char_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic [7:0]           rsp_color_ff, rsp_color_in;
   logic                 rsp_cov_ff, rsp_cov_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic                 accept;
   logic                 add_drop;
   logic                 tbl_we;
   logic                 art_we;
   logic                 issue;
   logic                 hit_take;
   logic                 miss;
   logic [AW-1:0]        art_waddr;
   logic [AW-1:0]        art_raddr;
   logic [spc_pkg::SUM_W-1:0] art_sum;
   logic [7:0]           art_rdata;
   spc_pkg::spc_obj_type tbl_wdata;
   spc_pkg::spc_obj_type tbl_rdata;
   spc_pkg::spc_hit_type hit;

   // Handshake and memory port control.
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      csr_ready = !busy;
      accept    = start && !busy;
      add_drop  = accept && (req_op == spc_pkg::OP_ADD) && (count_ff == COUNT_MAX);
      tbl_we    = accept && (req_op == spc_pkg::OP_ADD) && (count_ff != COUNT_MAX);
      art_we    = accept && (req_op == spc_pkg::OP_ART);
      art_waddr = AW'(req_art_addr);
      issue     = (state_ff == ST_SCAN) && (idx_ff < count_ff);
      hit_take  = (state_ff == ST_SCAN) && hit.vld && hit.hit;
      miss      = (state_ff == ST_SCAN) && (idx_ff == count_ff) && !rd_vld_ff && !hit_take;
      art_sum   = spc_pkg::SUM_W'(prod_ff) + spc_pkg::SUM_W'(part_ff);
      art_raddr = AW'(art_sum);
      tbl_wdata.x     = req_pos_x;
      tbl_wdata.y     = req_pos_y;
      tbl_wdata.w     = req_size_w;
      tbl_wdata.h     = req_size_h;
      tbl_wdata.color = req_color_in;
      tbl_wdata.base  = req_art_addr;
   end

   // Object table memory.
   spc_ram #(
      .WIDTH ($bits(spc_pkg::spc_obj_type)),
      .DEPTH (MAX_OBJECTS)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (count_ff[TW-1:0]),
      .wdata (tbl_wdata),
      .raddr (idx_ff[TW-1:0]),
      .rdata (tbl_rdata)
   );

   // Hit test behind the table read.
   spc_hit u_hit (
      .qx     (qx_ff),
      .qy     (qy_ff),
      .clock  (clock),
      .reset  (reset),
      .rd_vld (rd_vld_ff),
      .obj    (tbl_rdata),
      .hit    (hit)
   );

   // Art character memory.
   spc_ram #(
      .WIDTH (8),
      .DEPTH (ART_WORDS)
   ) u_art (
      .clock (clock),
      .we    (art_we),
      .waddr (art_waddr),
      .wdata (req_art_char),
      .raddr (art_raddr),
      .rdata (art_rdata)
   );

   // Sequencer: keep the table count, scan the table, form the art address and read it.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      prod_in   = prod_ff;
      part_in   = part_ff;
      color_in  = color_ff;
      rd_vld_in = issue;
      empty_char_in = (csr_valid && csr_ready) ? csr_empty_char : empty_char_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  spc_pkg::OP_ADD: begin
                     if (tbl_we) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  spc_pkg::OP_QUERY: begin
                     state_in = ST_SCAN;
                     idx_in   = '0;
                     qx_in    = req_pos_x;
                     qy_in    = req_pos_y;
                  end
                  spc_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (hit_take) begin
               state_in = ST_SUM;
               prod_in  = hit.dy * hit.w;
               part_in  = {1'b0, hit.base} + {5'd0, hit.dx};
               color_in = hit.color;
            end else if (miss) begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            state_in = ST_ART;
         end
         ST_ART: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_color_in = rsp_color_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_full_in  = rsp_full_ff;
      if (accept && (req_op != spc_pkg::OP_QUERY)) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = '0;
         rsp_color_in = '0;
         rsp_cov_in   = 1'b0;
         rsp_full_in  = add_drop;
      end else if (miss) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = empty_char_ff;
         rsp_color_in = (empty_char_ff == spc_pkg::SPACE_CHAR) ?
                        {spc_pkg::NO_COVER_COLOR[6:0], 1'b0} : spc_pkg::NO_COVER_COLOR;
         rsp_cov_in   = 1'b0;
         rsp_full_in  = 1'b0;
      end else if (state_ff == ST_ART) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = art_rdata;
         rsp_color_in = (art_rdata == spc_pkg::SPACE_CHAR) ?
                        {color_ff, 1'b0} : {1'b0, color_ff};
         rsp_cov_in   = 1'b1;
         rsp_full_in  = 1'b0;
      end
   end

   // Control registers are reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         empty_char_ff <= spc_pkg::EMPTY_CHAR_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         empty_char_ff <= empty_char_in;
      end
      idx_ff       <= idx_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      prod_ff      <= prod_in;
      part_ff      <= part_in;
      color_ff     <= color_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
      rsp_cov_ff   <= rsp_cov_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_char  = rsp_char_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_covered     = rsp_cov_ff;
   assign rsp_list_full   = rsp_full_ff;

   // The table never holds more than its depth.
   `SPC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_MAX, "object count above table depth")
   // The scan index never runs past the stored objects.
   `SPC_ASSERT_NOW(a_scan_index, state_ff == ST_SCAN, idx_ff <= count_ff, "scan index past count")
   // A query accept makes the block busy in the next cycle.
   `SPC_ASSERT_NEXT(a_query_busy, accept && (req_op == spc_pkg::OP_QUERY), busy, "query idle")
   // A covered beat only follows the art read of a hit.
   `SPC_ASSERT_NOW(a_cov_src, rsp_valid && rsp_covered, $past(state_ff == ST_ART), "stray covered")
   // A dropped add leaves the table count unchanged.
   `SPC_ASSERT_NEXT(a_full_drop, add_drop, count_ff == COUNT_MAX, "dropped add changed count")

endmodule

`default_nettype wire
